@@ hdl/tdfs_pkg.sv @@
// Shared types and constants for the timer divider factor search block.
package tdfs_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned CLK_W      = 28;
    localparam int unsigned DIVIDEND_W = CLK_W + 1;
    localparam int unsigned DIVISOR_W  = CLK_W;
    localparam int unsigned FACTOR_W   = 16;
    localparam int unsigned CNT_W      = $clog2(DIVIDEND_W);

    // Divisor source of the shared divider.
    typedef enum logic [1:0] {
        DSEL_RATE,
        DSEL_RATIO
    } t_dsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_RATE_WAIT,
        ST_CHECK,
        ST_LIMIT_WAIT,
        ST_STEP,
        ST_STEP_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  div_go;
        t_dsel dsel;
        logic  cap_div;
        logic  cap_start;
        logic  eval;
        logic  inc;
        logic  res_err;
        logic  res_direct;
        logic  res_sat;
        logic  res_final;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rate_zero;
        logic div_zero;
        logic div_le_lim;
        logic div_done;
        logic start_over;
        logic rem_zero;
        logic ratio_at_lim;
    } t_stat;

endpackage

@@ hdl/timer_divider_factor_search.sv @@
// Top level of the timer divider factor search block.
// Give the core clock, the bus clock and a wanted sample rate with start while busy is low;
// the word is taken at that edge. The timer clock is the bus clock when both clocks match
// and twice the bus clock otherwise; it is divided by the rate and the divider split into a
// 16-bit prescaler and a 16-bit reload value. One result word follows per word taken, shown
// for exactly one cycle with o_valid; it cannot be held off, so capture it then. Busy falls
// in the cycle that the result appears, and the next word may be given in that same cycle.
// The division by the rate and the division by each ratio share one radix-2 divider; the
// search start, the divider over FACTOR_LIMIT, comes from a registered reciprocal product.
// A rate of zero answers without a division; a divider up to FACTOR_LIMIT is answered
// directly; above that one division is run per ratio tried, up to FACTOR_LIMIT - 1 ratios.
module timer_divider_factor_search
    import tdfs_pkg::*;
#(
    parameter int unsigned FACTOR_LIMIT = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CLK_W-1:0]    i_core_clock_hz,
    input  logic [CLK_W-1:0]    i_bus_clock_hz,
    input  logic [CLK_W-1:0]    i_sample_rate_hz,
    output logic                o_valid,
    output logic [FACTOR_W-1:0] o_prescale_value,
    output logic [FACTOR_W-1:0] o_reload_value,
    output logic                o_status
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence the work: accept, divide, search, hand over.
    tdfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold operands, run the shared divider and register the result word.
    tdfs_dp #(
        .FACTOR_LIMIT (FACTOR_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_core_clock_hz  (i_core_clock_hz),
        .i_bus_clock_hz   (i_bus_clock_hz),
        .i_sample_rate_hz (i_sample_rate_hz),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_prescale_value (o_prescale_value),
        .o_reload_value   (o_reload_value),
        .o_status         (o_status)
    );

endmodule

@@ hdl/tdfs_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module tdfs_div
    import tdfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVIDEND_W-1:0] r_rem;
    logic [DIVISOR_W-1:0]  r_dsr;

    logic [DIVIDEND_W-1:0] trial;
    logic                  fits;
    logic [DIVIDEND_W-1:0] n_rem;
    logic [DIVIDEND_W-1:0] n_quot;

    always_comb begin
        trial  = {r_rem[DIVIDEND_W-2:0], r_quot[DIVIDEND_W-1]};
        fits   = trial >= {1'b0, r_dsr};
        n_rem  = fits ? (trial - {1'b0, r_dsr}) : trial;
        n_quot = {r_quot[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cnt  <= LAST_STEP;
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DIVISOR_W-1:0];

endmodule

@@ hdl/tdfs_dp.sv @@
// Datapath: operand registers, shared divider, ratio search and result registers.
module tdfs_dp
    import tdfs_pkg::*;
#(
    parameter int unsigned FACTOR_LIMIT = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [CLK_W-1:0]    i_core_clock_hz,
    input  logic [CLK_W-1:0]    i_bus_clock_hz,
    input  logic [CLK_W-1:0]    i_sample_rate_hz,
    output t_stat               o_stat,
    output logic                o_valid,
    output logic [FACTOR_W-1:0] o_prescale_value,
    output logic [FACTOR_W-1:0] o_reload_value,
    output logic                o_status
);

    localparam logic [FACTOR_W-1:0] LIM = FACTOR_W'(FACTOR_LIMIT);

    // Reciprocal of FACTOR_LIMIT, exact for every dividend of DIVIDEND_W bits.
    localparam int unsigned RECIP_W   = DIVIDEND_W + 1;
    localparam int unsigned LIM_SHIFT = DIVIDEND_W + $clog2(FACTOR_LIMIT);
    localparam logic [RECIP_W-1:0] LIM_RECIP =
        RECIP_W'(((64'd1 << LIM_SHIFT) + 64'(FACTOR_LIMIT) - 64'd1) / 64'(FACTOR_LIMIT));

    logic [DIVIDEND_W-1:0] r_tclk;
    logic [CLK_W-1:0]      r_rate;
    logic [DIVIDEND_W-1:0] r_div;
    logic [DIVIDEND_W-1:0] r_lim_quot;
    logic [FACTOR_W-1:0]   r_ratio;
    logic [FACTOR_W-1:0]   r_best_ratio;
    logic [FACTOR_W-1:0]   r_best_quot;
    logic [DIVISOR_W-1:0]  r_best_rem;
    logic                  r_valid;
    logic [FACTOR_W-1:0]   r_psc;
    logic [FACTOR_W-1:0]   r_arr;
    logic                  r_status;

    logic [DIVIDEND_W-1:0]         dvd;
    logic [DIVISOR_W-1:0]          dsr;
    logic                          div_done;
    logic [DIVIDEND_W-1:0]         quot;
    logic [DIVISOR_W-1:0]          rem;
    logic                          better;
    logic [FACTOR_W-1:0]           use_ratio;
    logic [FACTOR_W-1:0]           use_quot;
    logic [DIVIDEND_W+RECIP_W-1:0] lim_prod;

    always_comb begin
        dvd = (i_cmd.dsel == DSEL_RATE) ? r_tclk : r_div;
        case (i_cmd.dsel)
            DSEL_RATE:  dsr = r_rate;
            DSEL_RATIO: dsr = DIVISOR_W'(r_ratio);
            default:    dsr = DIVISOR_W'(r_ratio);
        endcase
    end

    tdfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (dvd),
        .i_divisor  (dsr),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Divider over FACTOR_LIMIT by reciprocal multiplication.
    always_comb begin
        lim_prod = {{RECIP_W{1'b0}}, r_div} * {{DIVIDEND_W{1'b0}}, LIM_RECIP};
    end

    // The current ratio wins only on a strictly smaller remainder.
    always_comb begin
        better    = rem < r_best_rem;
        use_ratio = better ? r_ratio : r_best_ratio;
        use_quot  = better ? quot[FACTOR_W-1:0] : r_best_quot;
    end

    always_comb begin
        o_stat.rate_zero    = r_rate == '0;
        o_stat.div_zero     = r_div == '0;
        o_stat.div_le_lim   = r_div <= DIVIDEND_W'(LIM);
        o_stat.div_done     = div_done;
        o_stat.start_over   = r_lim_quot >= DIVIDEND_W'(LIM);
        o_stat.rem_zero     = rem == '0;
        o_stat.ratio_at_lim = r_ratio >= LIM;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tclk <= (i_core_clock_hz == i_bus_clock_hz) ? {1'b0, i_bus_clock_hz}
                                                          : {i_bus_clock_hz, 1'b0};
            r_rate <= i_sample_rate_hz;
        end
        if (i_cmd.cap_div) begin
            r_div <= quot;
        end
        r_lim_quot <= DIVIDEND_W'(lim_prod >> LIM_SHIFT);
        if (i_cmd.cap_start) begin
            r_ratio    <= r_lim_quot[FACTOR_W-1:0] + 1'b1;
            r_best_rem <= '1;
        end else if (i_cmd.inc) begin
            r_ratio <= r_ratio + 1'b1;
        end
        if (i_cmd.eval && better) begin
            r_best_ratio <= r_ratio;
            r_best_quot  <= quot[FACTOR_W-1:0];
            r_best_rem   <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_err | i_cmd.res_direct | i_cmd.res_sat | i_cmd.res_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_err) begin
            r_psc    <= '0;
            r_arr    <= '0;
            r_status <= 1'b1;
        end else if (i_cmd.res_direct) begin
            r_psc    <= '0;
            r_arr    <= r_div[FACTOR_W-1:0] - 1'b1;
            r_status <= 1'b0;
        end else if (i_cmd.res_sat) begin
            r_psc    <= LIM - 1'b1;
            r_arr    <= LIM - 1'b1;
            r_status <= 1'b0;
        end else if (i_cmd.res_final) begin
            if (use_ratio > use_quot) begin
                r_psc <= use_quot - 1'b1;
                r_arr <= use_ratio - 1'b1;
            end else begin
                r_psc <= use_ratio - 1'b1;
                r_arr <= use_quot - 1'b1;
            end
            r_status <= 1'b0;
        end
    end

    assign o_valid          = r_valid;
    assign o_prescale_value = r_psc;
    assign o_reload_value   = r_arr;
    assign o_status         = r_status;

endmodule

@@ hdl/tdfs_ctrl.sv @@
// Controller: sequences the divisions and the ratio search.
module tdfs_ctrl
    import tdfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_RATE;
            end
            ST_RATE: begin
                n_state = i_stat.rate_zero ? ST_IDLE : ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (i_stat.div_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.div_zero || i_stat.div_le_lim) n_state = ST_IDLE;
                else n_state = ST_LIMIT_WAIT;
            end
            ST_LIMIT_WAIT: begin
                n_state = i_stat.start_over ? ST_IDLE : ST_STEP;
            end
            ST_STEP: begin
                n_state = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero || i_stat.ratio_at_lim) n_state = ST_IDLE;
                    else n_state = ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.dsel = DSEL_RATIO;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
            end
            ST_RATE: begin
                o_cmd.dsel    = DSEL_RATE;
                o_cmd.res_err = i_stat.rate_zero;
                o_cmd.div_go  = !i_stat.rate_zero;
            end
            ST_RATE_WAIT: begin
                o_cmd.dsel    = DSEL_RATE;
                o_cmd.cap_div = i_stat.div_done;
            end
            ST_CHECK: begin
                o_cmd.res_err    = i_stat.div_zero;
                o_cmd.res_direct = !i_stat.div_zero && i_stat.div_le_lim;
            end
            ST_LIMIT_WAIT: begin
                o_cmd.res_sat   = i_stat.start_over;
                o_cmd.cap_start = !i_stat.start_over;
            end
            ST_STEP: begin
                o_cmd.div_go = 1'b1;
            end
            ST_STEP_WAIT: begin
                o_cmd.eval      = i_stat.div_done;
                o_cmd.res_final = i_stat.div_done && (i_stat.rem_zero || i_stat.ratio_at_lim);
                o_cmd.inc       = i_stat.div_done && !i_stat.rem_zero && !i_stat.ratio_at_lim;
            end
            default: begin
                o_cmd.dsel = DSEL_RATIO;
            end
        endcase
    end

    assign o_busy = r_state != ST_IDLE;

endmodule

@@ hdl/tdfs_chk.sv @@
// Port-level checker for the timer divider factor search block, with its bind.
module tdfs_chk
    import tdfs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic [FACTOR_W-1:0] o_prescale_value,
    input logic [FACTOR_W-1:0] o_reload_value,
    input logic                o_status
);

    // A taken word keeps the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("word taken but block not busy");

    // A result word appears exactly when the block goes idle.
    a_valid_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $fell(busy))
        else $error("result word without end of work");

    a_idle_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("work ended without a result word");

    // An error word carries zero factors.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_prescale_value == '0 && o_reload_value == '0))
        else $error("error word with non-zero factors");

    // The reload always takes the larger factor.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |-> (o_prescale_value <= o_reload_value))
        else $error("prescaler above reload");

endmodule

bind timer_divider_factor_search tdfs_chk u_tdfs_chk (.*);
